[rtl/core/bzt_pkg.sv]
// ----------------------------------------------------------------------------
// bzt_pkg
// Shared types and constants for the buzzer tone generator: operation
// codes, register indexes, field widths and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bzt_pkg;

  // field widths
  localparam int FREQ_W  = 16;
  localparam int DUR_W   = 16;
  localparam int VOL_W   = 8;
  localparam int TOP_W   = 8;
  localparam int TPU_W   = 4;
  localparam int LEN_W   = 19;
  localparam int LVL_W   = 9;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // shared divider: 32 quotient bits per command
  localparam int DIV_W     = 32;
  localparam int DIV_STEPS = DIV_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // half a second in microseconds: len = 500000 / f
  localparam logic [DIV_W-1:0] HALF_SEC_US = 32'd500000;

  // count = 2*f*dur/1000 = (f*dur/4)/125; the divide by 125 is a
  // multiply by ceil(2^36/125), exact for any 30-bit dividend
  localparam int CNT_RECIP_W = 30;
  localparam int CNT_SHIFT   = 36;
  localparam int CNT_Q_W     = 2 * CNT_RECIP_W - CNT_SHIFT;
  localparam logic [CNT_RECIP_W-1:0] CNT_RECIP = 30'd549755814;

  // reset values
  localparam logic [TOP_W-1:0] PWM_TOP_RST = 8'd100;
  localparam logic [TPU_W-1:0] TPU_RST     = 4'd10;
  localparam logic [LEN_W-1:0] LEN_RST     = 19'd100;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PLAY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic tick;    // apply a time tick
    logic load;    // capture a play command, start the divider
    logic step;    // one divider step
    logic commit;  // apply the play command
  } cmd_t;

  typedef struct packed {
    logic buzzer_out;
    logic playing;
  } res_t;

  typedef struct packed {
    logic playing;
    logic gate_on;
  } stat_t;

endpackage

`default_nettype wire

[rtl/core/bzt_ctrl.sv]
// ----------------------------------------------------------------------------
// bzt_ctrl
// Controller: accepts items, sequences the divider for play commands and
// tells the top level when a result is ready to be registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bzt_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        opcode,
  input  wire logic        out_space,
  output logic             in_tready,
  output logic             out_load,
  output bzt_pkg::cmd_t    cmd
);
  import bzt_pkg::*;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               accept;

  assign in_tready = (state_r == ST_IDLE) && out_space;
  assign accept    = in_tvalid && in_tready;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd        = '0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_PLAY) begin
            cmd.load  = 1'b1;
            step_nxt  = '0;
            state_nxt = ST_DIV;
          end else begin
            cmd.tick = 1'b1;
            out_load = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_space) begin
          cmd.commit = 1'b1;
          out_load   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bzt_dp.sv]
// ----------------------------------------------------------------------------
// bzt_dp
// Datapath: configuration registers, PWM counter, microsecond timebase,
// half-wave counting, the bit-serial divider for the half-wave length and
// a registered reciprocal multiply for the half-wave count.
// ----------------------------------------------------------------------------
`default_nettype none

module bzt_dp #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bzt_pkg::cmd_t                     cmd,
  input  wire logic [bzt_pkg::FREQ_W-1:0]        frequency,
  input  wire logic [bzt_pkg::DUR_W-1:0]         dur_ms,
  input  wire logic [bzt_pkg::VOL_W-1:0]         volume,
  input  wire logic                              cfg_we,
  input  wire logic [bzt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bzt_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bzt_pkg::res_t                          res,
  output bzt_pkg::stat_t                         stat
);
  import bzt_pkg::*;

  localparam logic [DIV_W:0] CMAX = (33'd1 << COUNT_BITS) - 33'd1;

  // configuration
  logic [TOP_W-1:0]      pwm_top_r;
  logic [TPU_W-1:0]      tpu_r;

  // tone state
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [COUNT_BITS-1:0] left_r, left_nxt;
  logic                  phase_r, phase_nxt;
  logic                  gate_r, gate_nxt;
  logic [TPU_W-1:0]      prescale_r, prescale_nxt;
  logic [LEN_W-1:0]      elapsed_r, elapsed_nxt;
  logic [TOP_W-1:0]      cnt_r, cnt_nxt;
  logic [LVL_W-1:0]      level_r, level_nxt;

  // command operands, divider lane and count multiply
  logic [FREQ_W-1:0]     freq_r;
  logic [VOL_W-1:0]      vol_r;
  logic [DIV_W-1:0]      qa_r, qa_nxt;
  logic [FREQ_W-1:0]     ra_r, ra_nxt;
  logic [DIV_W-1:0]      prod_r;
  logic [CNT_Q_W-1:0]    qb_r;

  // scratch values
  logic [TPU_W-1:0]      ps_inc;
  logic [LEN_W-1:0]      el_inc;
  logic [COUNT_BITS-1:0] left_dec;
  logic [FREQ_W:0]       ra_sh;
  logic [2*CNT_RECIP_W-1:0] prod_scaled;
  logic [DIV_W:0]        qb_wide;
  logic [LEN_W-1:0]      new_len;
  logic [LVL_W-1:0]      vol_lvl, top_lvl, new_lvl;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  cmd_valid;

  assign ps_inc   = prescale_r + 1'b1;
  assign el_inc   = elapsed_r + 1'b1;
  assign left_dec = left_r - 1'b1;
  assign ra_sh    = {ra_r, qa_r[DIV_W-1]};

  // f*dur/4 times the reciprocal of 125
  assign prod_scaled = prod_r[DIV_W-1:2] * CNT_RECIP;
  assign qb_wide     = {{(DIV_W + 1 - CNT_Q_W){1'b0}}, qb_r};

  // play command results taken from the finished divider, the count multiply and the operands
  assign new_len   = qa_r[LEN_W-1:0];
  assign vol_lvl   = {1'b0, vol_r} + 1'b1;
  assign top_lvl   = {1'b0, pwm_top_r} + 1'b1;
  assign new_lvl   = (vol_lvl > top_lvl) ? top_lvl : vol_lvl;
  assign new_cnt   = (qb_wide > CMAX) ? CMAX[COUNT_BITS-1:0] : qb_wide[COUNT_BITS-1:0];
  assign cmd_valid = (vol_r != '0) && (freq_r != '0);

  // next-state logic
  always_comb begin
    len_nxt      = len_r;
    left_nxt     = left_r;
    phase_nxt    = phase_r;
    gate_nxt     = gate_r;
    prescale_nxt = prescale_r;
    elapsed_nxt  = elapsed_r;
    cnt_nxt      = cnt_r;
    level_nxt    = level_r;
    qa_nxt       = qa_r;
    ra_nxt       = ra_r;

    // time tick: pwm counter always, timebase only while playing
    if (cmd.tick) begin
      cnt_nxt = (cnt_r >= pwm_top_r) ? '0 : cnt_r + 1'b1;
      if (left_r != '0) begin
        if (ps_inc >= tpu_r) begin
          prescale_nxt = '0;
          if (el_inc >= len_r) begin
            elapsed_nxt = '0;
            left_nxt    = left_dec;
            if (left_dec == '0) begin
              gate_nxt = 1'b0;
            end else begin
              gate_nxt  = phase_r;
              phase_nxt = ~phase_r;
            end
          end else begin
            elapsed_nxt = el_inc;
          end
        end else begin
          prescale_nxt = ps_inc;
        end
      end
    end

    // divider start: 500000/f
    if (cmd.load) begin
      qa_nxt = HALF_SEC_US;
      ra_nxt = '0;
    end

    // one restoring step
    if (cmd.step) begin
      if (ra_sh >= {1'b0, freq_r}) begin
        ra_nxt = FREQ_W'(ra_sh - {1'b0, freq_r});
        qa_nxt = {qa_r[DIV_W-2:0], 1'b1};
      end else begin
        ra_nxt = ra_sh[FREQ_W-1:0];
        qa_nxt = {qa_r[DIV_W-2:0], 1'b0};
      end
    end

    // apply the play command
    if (cmd.commit && cmd_valid) begin
      if ((left_r == '0) || (len_r != new_len)) begin
        phase_nxt    = 1'b0;
        len_nxt      = new_len;
        prescale_nxt = '0;
        elapsed_nxt  = '0;
      end
      level_nxt = new_lvl;
      left_nxt  = new_cnt;
      if (new_cnt == '0) begin
        gate_nxt = 1'b0;
      end
    end
  end

  // result: a tick shows the pin before it advances, a command after it
  always_comb begin
    if (cmd.commit) begin
      res.buzzer_out = gate_nxt && ({1'b0, cnt_r} < level_nxt);
    end else begin
      res.buzzer_out = gate_r && ({1'b0, cnt_r} < level_r);
    end
    res.playing  = (left_nxt != '0);
    stat.playing = (left_r != '0);
    stat.gate_on = gate_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_top_r <= PWM_TOP_RST;
      tpu_r     <= TPU_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PWM_TOP:      pwm_top_r <= cfg_data;
        CFG_TICKS_PER_US: tpu_r     <= cfg_data[TPU_W-1:0];
        default: ;
      endcase
    end
  end

  // tone state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= LEN_RST;
      left_r     <= '0;
      phase_r    <= 1'b0;
      gate_r     <= 1'b0;
      prescale_r <= '0;
      elapsed_r  <= '0;
      cnt_r      <= '0;
      level_r    <= '0;
    end else begin
      len_r      <= len_nxt;
      left_r     <= left_nxt;
      phase_r    <= phase_nxt;
      gate_r     <= gate_nxt;
      prescale_r <= prescale_nxt;
      elapsed_r  <= elapsed_nxt;
      cnt_r      <= cnt_nxt;
      level_r    <= level_nxt;
    end
  end

  // operands, divider lane and count multiply
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq_r <= frequency;
      vol_r  <= volume;
      prod_r <= frequency * dur_ms;
    end
    if (cmd.step) begin
      qb_r <= prod_scaled[2*CNT_RECIP_W-1:CNT_SHIFT];
    end
    qa_r <= qa_nxt;
    ra_r <= ra_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/buzzer_tone_generator.sv]
// ----------------------------------------------------------------------------
// buzzer_tone_generator
// PWM buzzer tone generator: play commands and time ticks in, one pin
// level and playing flag out per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   stream of items; in_tuser is the opcode (tick or play command),
//          in_tdata carries frequency, duration in ms and volume.
//   out_*  one result beat per input beat: pin level and playing flag.
//   cfg_*  register writes (pwm_top, ticks_per_us), always ready; write
//          only while no item is in flight.
//   A tick is handled in the cycle it is accepted and its result is
//   valid the next cycle, so ticks run at one per cycle while the
//   receiver keeps up. A play command runs a 32-step bit-serial divide
//   for the half-wave length while a registered reciprocal multiply
//   forms the half-wave count; its result is loaded into the output
//   register once the divide is done and the register has space, and the
//   next item can follow after that; no new item is accepted meanwhile.
//   The result sits in an output register; the next item is accepted
//   while it waits as long as the receiver takes it in the same cycle.
//   When the receiver stalls, input stalls once the register is full.
//   Reset restores both registers to their defaults and leaves the block
//   idle, pin off, ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module buzzer_tone_generator #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata: frequency[15:0], dur_ms[31:16], volume[39:32]
  input  wire logic [bzt_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: opcode[0]
  input  wire logic                              in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tdata: buzzer_out[0], playing[1], zero[7:2]
  output logic [bzt_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bzt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bzt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bzt_pkg::*;

  cmd_t  cmd;
  res_t  res;
  stat_t stat;
  logic  out_space;
  logic  out_load;
  logic  out_valid_r;
  res_t  out_res_r;

  assign cfg_ready = 1'b1;
  assign out_space = !out_valid_r || out_tready;

  bzt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .opcode    (in_tuser),
    .out_space (out_space),
    .in_tready (in_tready),
    .out_load  (out_load),
    .cmd       (cmd)
  );

  bzt_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .frequency   (in_tdata[15:0]),
    .dur_ms      (in_tdata[31:16]),
    .volume      (in_tdata[39:32]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .res         (res),
    .stat        (stat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.playing, out_res_r.buzzer_out};

  // gate is never on without half-waves left
  a_gate_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.playing |-> !stat.gate_on)
    else $error("gate on while idle");

  // a play command blocks input on the next cycle
  a_play_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_PLAY)) |=> !in_tready)
    else $error("input accepted during play command");

  // a tick result is presented on the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_TICK)) |=> out_tvalid)
    else $error("tick result missing");

endmodule

`default_nettype wire

[bench/buzzer_tone_generator_tb.sv]
// ----------------------------------------------------------------------------
// buzzer_tone_generator_tb
// Self-checking bench for the buzzer tone generator. A bit-accurate tone
// model predicts the pin level and playing flag for every accepted tick
// or play command. Results are checked in order. Directed edge cases run
// first, then tone sequences with random content under several register
// settings, with random gaps on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buzzer_tone_generator_tb;
  import bzt_pkg::*;

  localparam int COUNT_BITS    = 24;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 50;

  // tone model and store of expected pin beats
  class tone_scoreboard;
    logic [TOP_W-1:0]      top;
    logic [TPU_W-1:0]      tpu;
    logic [LEN_W-1:0]      hw_len;
    logic [COUNT_BITS-1:0] hw_left;
    logic                  phase;
    logic                  gate;
    logic [TPU_W-1:0]      prescale;
    logic [LEN_W-1:0]      elapsed;
    logic [TOP_W-1:0]      pwm_cnt;
    logic [LVL_W-1:0]      level;
    res_t                  pin_beats_q[$];
    int                    errors;

    function new();
      top      = PWM_TOP_RST;
      tpu      = TPU_RST;
      hw_len   = LEN_RST;
      hw_left  = '0;
      phase    = 1'b0;
      gate     = 1'b0;
      prescale = '0;
      elapsed  = '0;
      pwm_cnt  = '0;
      level    = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PWM_TOP:      top = val[TOP_W-1:0];
        CFG_TICKS_PER_US: tpu = val[TPU_W-1:0];
        default: ;
      endcase
    endfunction

    function logic pin_now();
      return gate && ({1'b0, pwm_cnt} < level);
    endfunction

    // one pwm clock; the timebase only runs while a tone plays
    function void advance_tick();
      if (pwm_cnt >= top) pwm_cnt = '0;
      else pwm_cnt = pwm_cnt + 1'b1;
      if (hw_left == 0) return;
      prescale = prescale + 1'b1;
      if (prescale >= tpu) begin
        prescale = '0;
        elapsed  = elapsed + 1'b1;
        if (elapsed >= hw_len) begin
          elapsed = '0;
          hw_left = hw_left - 1'b1;
          if (hw_left == 0) begin
            gate = 1'b0;
          end else begin
            gate  = phase;
            phase = ~phase;
          end
        end
      end
    endfunction

    function void apply_play(logic [FREQ_W-1:0] f, logic [DUR_W-1:0] d,
                             logic [VOL_W-1:0] v);
      longint unsigned span;
      longint unsigned span_max;
      logic [LEN_W-1:0] len;
      logic [LVL_W-1:0] lvl;
      logic [LVL_W-1:0] lvl_max;
      if (v == 0 || f == 0) return;
      len = LEN_W'(1000000 / (2 * int'(f)));
      // restart phase only from idle or on a new half-wave length
      if (hw_left == 0 || hw_len != len) begin
        phase    = 1'b0;
        hw_len   = len;
        prescale = '0;
        elapsed  = '0;
      end
      lvl     = {1'b0, v} + 9'd1;
      lvl_max = {1'b0, top} + 9'd1;
      if (lvl > lvl_max) lvl = lvl_max;
      level    = lvl;
      span     = (longint'(f) * 2 * longint'(d)) / 1000;
      span_max = (64'd1 << COUNT_BITS) - 1;
      if (span > span_max) span = span_max;
      hw_left = COUNT_BITS'(span);
      if (hw_left == 0) gate = 1'b0;
    endfunction

    function void accept_item(logic op, logic [FREQ_W-1:0] f, logic [DUR_W-1:0] d,
                              logic [VOL_W-1:0] v);
      res_t r;
      if (op == OP_TICK) begin
        r.buzzer_out = pin_now();
        advance_tick();
      end else begin
        apply_play(f, d, v);
        r.buzzer_out = pin_now();
      end
      r.playing = (hw_left != 0);
      pin_beats_q.push_back(r);
    endfunction

    function void check_pin_beat(logic [OUT_TDATA_W-1:0] beat);
      res_t want;
      if (pin_beats_q.size() == 0) begin
        $error("result beat 0x%02h with no item pending", beat);
        errors++;
        return;
      end
      want = pin_beats_q.pop_front();
      if (beat[0] !== want.buzzer_out) begin
        $error("buzzer_out mismatch: expected %0b, actual %0b", want.buzzer_out, beat[0]);
        errors++;
      end
      if (beat[1] !== want.playing) begin
        $error("playing mismatch: expected %0b, actual %0b", want.playing, beat[1]);
        errors++;
      end
      if (beat[OUT_TDATA_W-1:2] !== '0) begin
        $error("pad mismatch: expected 0, actual %0h", beat[OUT_TDATA_W-1:2]);
        errors++;
      end
    endfunction

    function int pending();
      return pin_beats_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  tone_scoreboard    tones;
  bit                tx_idling;
  bit                rx_idling;
  bit                hold_req;
  int                cycle_count = 0;
  logic [FREQ_W-1:0] last_freq = 16'd1000;

  buzzer_tone_generator #(
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit idling);
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly high tones for short half-waves, sometimes a repeat of the last one
  function automatic logic [FREQ_W-1:0] pick_freq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) last_freq = FREQ_W'($urandom_range(5000, 65535));
    else if (r < 85) last_freq = last_freq;
    else last_freq = FREQ_W'($urandom_range(1, 65535));
    return last_freq;
  endfunction

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap(rx_idling);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tones.check_pin_beat(out_tdata);
  end

  // one input beat; valid stays high into the next beat when no gap follows
  task automatic send_item(input logic op, input logic [FREQ_W-1:0] f,
                           input logic [DUR_W-1:0] d, input logic [VOL_W-1:0] v);
    int gap;
    gap = pick_gap(tx_idling);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {v, d, f};
    do @(posedge clk); while (!in_tready);
    tones.accept_item(op, f, d, v);
  endtask

  // tick with junk in the unused data fields
  task automatic send_tick();
    send_item(OP_TICK, FREQ_W'($urandom), DUR_W'($urandom), VOL_W'($urandom));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tones.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, upper data bits of the timebase write are junk
  task automatic set_config(input logic [TOP_W-1:0] top, input logic [TPU_W-1:0] tpu);
    logic [CFG_DATA_W-1:0] tpu_word;
    tpu_word   = {4'($urandom), tpu};
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PWM_TOP;
    cfg_data  <= top;
    do @(posedge clk); while (!cfg_ready);
    tones.write_reg(CFG_PWM_TOP, top);
    cfg_index <= CFG_TICKS_PER_US;
    cfg_data  <= tpu_word;
    do @(posedge clk); while (!cfg_ready);
    tones.write_reg(CFG_TICKS_PER_US, tpu_word);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // tone sequences: a play command followed by a run of ticks
  task automatic run_phase(input int budget, input bit long_tone);
    int sent;
    int ticks;
    int kind;
    logic [FREQ_W-1:0] f;
    logic [DUR_W-1:0]  d;
    logic [VOL_W-1:0]  v;
    sent = 0;
    // shortest complete tone, long enough to play out to the end
    if (long_tone) begin
      send_item(OP_PLAY, 16'hFFFF, 16'd1, VOL_W'($urandom_range(1, 255)));
      repeat (1000) send_tick();
    end
    while (sent < budget) begin
      kind = $urandom_range(0, 99);
      f    = FREQ_W'($urandom);
      d    = DUR_W'($urandom);
      v    = VOL_W'($urandom);
      if (kind < 70) begin
        f = pick_freq();
        d = DUR_W'($urandom_range(1, 4));
        v = VOL_W'($urandom_range(1, 255));
      end else if (kind < 80) begin
        // ignored command
        if ($urandom_range(0, 1)) f = '0;
        else v = '0;
      end else if (kind >= 92) begin
        // zero half-wave count
        v = VOL_W'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) begin
          f = FREQ_W'($urandom_range(1, 65535));
          d = '0;
        end else begin
          f = FREQ_W'($urandom_range(1, 499));
          d = 16'd1;
        end
      end
      send_item(OP_PLAY, f, d, v);
      if ($urandom_range(0, 99) < 70) ticks = $urandom_range(2, 30);
      else ticks = $urandom_range(30, 150);
      repeat (ticks) send_tick();
      sent += ticks + 1;
    end
    wait_idle();
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tuser  <= OP_TICK;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_PWM_TOP;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    tx_idling  = 1'b1;
    rx_idling  = 1'b1;
    hold_req   = 1'b0;
    tones      = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, ignored commands, zero count, saturation, restarts
    send_tick();
    send_item(OP_PLAY, 16'd0, 16'd100, 8'd50);
    send_item(OP_PLAY, 16'd1000, 16'd100, 8'd0);
    send_item(OP_PLAY, 16'hFFFF, 16'd0, 8'hFF);
    send_item(OP_PLAY, 16'd1, 16'd1, 8'd1);
    send_item(OP_PLAY, 16'hFFFF, 16'hFFFF, 8'hFF);
    repeat (3) send_tick();
    send_item(OP_PLAY, 16'hFFFF, 16'd1000, 8'd200);
    send_tick();
    send_item(OP_PLAY, 16'd30000, 16'd10, 8'd128);
    repeat (3) send_tick();
    send_item(OP_PLAY, 16'd1, 16'hFFFF, 8'd1);
    send_item(OP_PLAY, 16'd2, 16'hFFFF, 8'd254);
    send_tick();
    send_item(OP_PLAY, 16'hFFFF, 16'd0, 8'd7);
    repeat (2) send_tick();
    wait_idle();

    // widest pwm range, one tick per microsecond
    set_config(8'd255, 4'd1);
    run_phase(80, 1'b1);

    // narrowest range, zero timebase setting, long receiver hold-off
    set_config(8'd1, 4'd0);
    hold_req = 1'b1;
    run_phase(80, 1'b0);

    set_config(TOP_W'($urandom_range(2, 254)), 4'd15);
    run_phase(80, 1'b0);

    set_config(PWM_TOP_RST, TPU_RST);
    run_phase(80, 1'b0);

    // no idling on either side
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    set_config(TOP_W'($urandom_range(1, 255)), TPU_W'($urandom_range(1, 15)));
    run_phase(80, 1'b0);

    tx_idling = 1'b1;
    rx_idling = 1'b1;
    set_config(TOP_W'($urandom_range(1, 255)), 4'd1);
    run_phase(80, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tones.errors == 0 && tones.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[buzzer_tone_generator.f]
rtl/core/bzt_pkg.sv
rtl/core/bzt_ctrl.sv
rtl/core/bzt_dp.sv
rtl/core/buzzer_tone_generator.sv
bench/buzzer_tone_generator_tb.sv
